// ===== rtl/core/kss_pkg.sv =====
package kss_pkg;

  // Store geometry
  localparam int unsigned NumStacks = 4;
  localparam int unsigned Depth     = 256;
  localparam int unsigned DataW     = 32;

  // Fixed field widths of the item ports
  localparam int unsigned ValueW  = 32;
  localparam int unsigned SidW    = 2;
  localparam int unsigned StatusW = 2;

  // Slot index carries one extra code for null, which is Depth itself
  localparam int unsigned IdxW      = $clog2(Depth + 1);
  localparam int unsigned SlotW     = $clog2(Depth);
  localparam int unsigned StackIdxW = (NumStacks > 1) ? $clog2(NumStacks) : 1;

  localparam logic [IdxW-1:0] NullIdx = IdxW'(Depth);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Access to the link store: one read at accept, one write-back at execute
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_slot;
    logic            wr_en;
    logic [IdxW-1:0] wr_slot;
    logic [IdxW-1:0] wr_link;
  } link_req_t;

endpackage

// ===== rtl/core/kss_ram.sv =====
module kss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/kss_link_store.sv =====
module kss_link_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kss_pkg::link_req_t          req_i,
  output logic [kss_pkg::IdxW-1:0]    link_o
);
  import kss_pkg::*;

  // Slots at or above the fill mark were never written and link to the next
  logic [IdxW-1:0] fill_q;
  logic [IdxW-1:0] rd_slot_q;
  logic            fresh_q;
  logic [IdxW-1:0] ram_link;

  kss_ram #(
    .Width (IdxW),
    .Depth (Depth)
  ) u_link_ram (
    .clk_i     (clk_i),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.rd_slot[SlotW-1:0]),
    .rd_data_o (ram_link),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_slot[SlotW-1:0]),
    .wr_data_i (req_i.wr_link)
  );

  // Advance the fill mark when the first untouched slot gets written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (req_i.wr_en && (req_i.wr_slot == fill_q)) begin
      fill_q <= IdxW'(fill_q + 1'b1);
    end
  end

  // Remember which slot was read and whether it is still untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b0;
    end else if (req_i.rd_en) begin
      fresh_q <= (req_i.rd_slot >= fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_slot_q <= req_i.rd_slot;
    end
  end

  // The last slot plus one is the null code, so no end case is needed
  assign link_o = fresh_q ? IdxW'(rd_slot_q + 1'b1) : ram_link;

endmodule

// ===== rtl/core/k_stacks_shared_store.sv =====
// Several LIFO stacks sharing one store of slots, chained by a link store.
//
// Command channel: an item (action_i, stack_id_i, push_value_i) is taken at
// a rising edge where start is high and busy is low. action_i selects push
// or pop on stack stack_id_i.
// Result channel: done_o is high for exactly one cycle with pop_value_o,
// status_o (done, overflow, underflow), store_full_o and stack_empty_o.
// The receiver cannot stall; each result is taken in the cycle it shows.
//
// Timing: an accepted item moves to S_EXEC, where the heads, free list and
// stores are updated; done_o is registered from S_EXEC. busy is high in
// S_EXEC, so a new item is not taken until the current one has executed.
// This pacing is set by the link-store read issued at accept, whose data is
// needed before the head and free-list update and write-back in S_EXEC.
//
// Reset: all stacks empty, free list starts at slot 0. The link store gets
// no clearing pass; a fill mark stands in for its sequential initial chain,
// so items are accepted right after reset.
module k_stacks_shared_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [kss_pkg::SidW-1:0]           stack_id_i,
  input  logic signed [kss_pkg::ValueW-1:0]  push_value_i,
  output logic                               done_o,
  output logic signed [kss_pkg::ValueW-1:0]  pop_value_o,
  output logic [kss_pkg::StatusW-1:0]        status_o,
  output logic                               store_full_o,
  output logic                               stack_empty_o
);
  import kss_pkg::*;

  state_e state_q, state_d;

  logic [IdxW-1:0] head_q [NumStacks];
  logic [IdxW-1:0] head_d [NumStacks];
  logic [IdxW-1:0] free_head_q, free_head_d;

  // Item held across the execute cycle
  action_e            act_q;
  logic [SidW-1:0]    sid_q;
  logic [DataW-1:0]   val_q;
  logic [IdxW-1:0]    slot_q;
  logic               err_q;
  logic               id_ok_q;

  // Accept-side signals
  logic               accept;
  logic               id_ok;
  logic [IdxW-1:0]    sel_slot;
  logic               sel_err;

  // Store access
  link_req_t          link_req;
  logic [IdxW-1:0]    rd_link;
  logic signed [DataW-1:0] rd_data;
  logic               data_rd_en;
  logic               data_wr_en;

  // Result registers
  logic                      done_q;
  logic signed [ValueW-1:0]  pop_value_q, pop_value_d;
  status_e                   status_q, status_d;
  logic                      full_q, full_d;
  logic                      empty_q, empty_d;
  logic                      exec;

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;
  assign exec   = (state_q == S_EXEC);
  assign id_ok  = (32'(stack_id_i) < NumStacks);

  // Pick the slot the item works on and spot overflow or underflow
  always_comb begin
    sel_slot = NullIdx;
    sel_err  = 1'b1;
    unique case (action_e'(action_i))
      ACT_PUSH: begin
        sel_slot = free_head_q;
        sel_err  = !id_ok || (free_head_q == NullIdx);
      end
      ACT_POP: begin
        if (id_ok) begin
          sel_slot = head_q[stack_id_i[StackIdxW-1:0]];
        end
        sel_err = (sel_slot == NullIdx);
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Issue the reads at accept; at execute update heads, free list, write back and form the result
  always_comb begin
    head_d      = head_q;
    free_head_d = free_head_q;
    link_req.rd_en   = accept && !sel_err;
    link_req.rd_slot = sel_slot;
    link_req.wr_en   = 1'b0;
    link_req.wr_slot = slot_q;
    link_req.wr_link = free_head_q;
    data_rd_en  = accept && !sel_err && (action_e'(action_i) == ACT_POP);
    data_wr_en  = 1'b0;
    pop_value_d = '0;
    status_d    = ST_DONE;
    full_d      = (free_head_q == NullIdx);
    empty_d     = id_ok_q ? (head_q[sid_q[StackIdxW-1:0]] == NullIdx) : 1'b1;
    if (exec) begin
      priority if (err_q) begin
        status_d = (act_q == ACT_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
      end else if (act_q == ACT_PUSH) begin
        free_head_d                   = rd_link;
        head_d[sid_q[StackIdxW-1:0]]  = slot_q;
        link_req.wr_en                = 1'b1;
        link_req.wr_link              = head_q[sid_q[StackIdxW-1:0]];
        data_wr_en                    = 1'b1;
        full_d                        = (rd_link == NullIdx);
        empty_d                       = 1'b0;
      end else begin
        free_head_d                   = slot_q;
        head_d[sid_q[StackIdxW-1:0]]  = rd_link;
        link_req.wr_en                = 1'b1;
        link_req.wr_link              = free_head_q;
        pop_value_d                   = ValueW'(rd_data);
        full_d                        = 1'b0;
        empty_d                       = (rd_link == NullIdx);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < NumStacks; i++) begin
        head_q[i] <= NullIdx;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      done_q      <= exec;
      head_q      <= head_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_e'(action_i);
      sid_q   <= stack_id_i;
      val_q   <= DataW'(push_value_i);
      slot_q  <= sel_slot;
      err_q   <= sel_err;
      id_ok_q <= id_ok;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (exec) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      full_q      <= full_d;
      empty_q     <= empty_d;
    end
  end

  kss_link_store u_link (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .link_o (rd_link)
  );

  kss_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_data_ram (
    .clk_i     (clk_i),
    .rd_en_i   (data_rd_en),
    .rd_addr_i (sel_slot[SlotW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (data_wr_en),
    .wr_addr_i (slot_q[SlotW-1:0]),
    .wr_data_i (val_q)
  );

  assign done_o        = done_q;
  assign pop_value_o   = pop_value_q;
  assign status_o      = status_q;
  assign store_full_o  = full_q;
  assign stack_empty_o = empty_q;

endmodule

// ===== rtl/core/kss_checker.sv =====
module kss_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done_o,
  input logic signed [kss_pkg::ValueW-1:0]  pop_value_o,
  input logic [kss_pkg::StatusW-1:0]        status_o
);
  import kss_pkg::*;

  // An accepted item occupies the block for the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Every accepted item yields its result strobe, registered from the execute state
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  // Results come out only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // One strobe per item
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A failed step returns zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_DONE)) |-> (pop_value_o == '0))
    else $error("nonzero data on overflow or underflow");

endmodule

bind k_stacks_shared_store kss_checker u_kss_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
  import kss_pkg::*;

  // One expected step result
  typedef struct {
    logic [ValueW-1:0]  pop_value;
    status_e            status;
    logic               full;
    logic               empty;
  } step_result_t;

  // Tracks the shared store and the expected result of every accepted item
  class stack_scoreboard;
    logic [DataW-1:0] slot_data [Depth];
    logic [IdxW-1:0]  slot_link [Depth];
    logic [IdxW-1:0]  stack_head [NumStacks];
    logic [IdxW-1:0]  free_head;
    int unsigned      used;
    int unsigned      errors;
    int unsigned      results_seen;
    step_result_t     step_results_q[$];

    function new();
      for (int i = 0; i < Depth; i++) begin
        slot_data[i] = '0;
        slot_link[i] = IdxW'(i + 1);
      end
      for (int s = 0; s < NumStacks; s++) begin
        stack_head[s] = NullIdx;
      end
      free_head    = '0;
      used         = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Apply one accepted item to the store copy and queue its result
    function void note_item(action_e act, logic [SidW-1:0] sid,
                            logic [ValueW-1:0] value);
      step_result_t    r;
      logic [IdxW-1:0] slot;
      bit              valid_id;
      valid_id    = sid < NumStacks;
      r.pop_value = '0;
      r.status    = ST_DONE;
      if (act == ACT_PUSH) begin
        slot = free_head;
        if (!valid_id || slot == NullIdx) begin
          r.status = ST_OVERFLOW;
        end else begin
          free_head       = slot_link[slot];
          slot_link[slot] = stack_head[sid];
          stack_head[sid] = slot;
          slot_data[slot] = value[DataW-1:0];
          used++;
        end
      end else begin
        slot = valid_id ? stack_head[sid] : NullIdx;
        if (slot == NullIdx) begin
          r.status = ST_UNDERFLOW;
        end else begin
          stack_head[sid] = slot_link[slot];
          slot_link[slot] = free_head;
          free_head       = slot;
          r.pop_value     = ValueW'($signed(slot_data[slot]));
          used--;
        end
      end
      r.empty = valid_id ? (stack_head[sid] == NullIdx) : 1'b1;
      r.full  = (free_head == NullIdx);
      step_results_q.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("t=%0t result %0d: %s got %0h want %0h",
               $time, results_seen, field, got, want);
    endtask

    // Compare one result against the oldest expectation
    task check_result(logic [ValueW-1:0] pop_value, logic [StatusW-1:0] status,
                      logic full, logic empty);
      step_result_t want;
      results_seen++;
      if (step_results_q.size() == 0) begin
        report("unexpected result, pop_value", pop_value, '0);
        return;
      end
      want = step_results_q.pop_front();
      if (pop_value !== want.pop_value) report("pop_value", pop_value, want.pop_value);
      if (status !== want.status)       report("status", status, want.status);
      if (full !== want.full)           report("store_full", full, want.full);
      if (empty !== want.empty)         report("stack_empty", empty, want.empty);
    endtask
  endclass

  typedef enum {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } walk_mode_e;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned TailCycles  = 8;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      action_i;
  logic [SidW-1:0]           stack_id_i;
  logic signed [ValueW-1:0]  push_value_i;
  logic                      done_o;
  logic signed [ValueW-1:0]  pop_value_o;
  logic [StatusW-1:0]        status_o;
  logic                      store_full_o;
  logic                      stack_empty_o;

  stack_scoreboard sb;
  int unsigned     sender_idle_pct;

  k_stacks_shared_store u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .stack_id_i    (stack_id_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .store_full_o  (store_full_o),
    .stack_empty_o (stack_empty_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every result in the cycle it shows
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      sb.check_result(pop_value_o, status_o, store_full_o, stack_empty_o);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(action_e act, logic [SidW-1:0] sid,
                           logic [ValueW-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    action_i     <= act;
    stack_id_i   <= sid;
    push_value_i <= value;
    do @(posedge clk_i); while (busy);
    sb.note_item(act, sid, value);
  endtask

  // Random walk between filling the store, draining it and mixed traffic
  task automatic run_random(int unsigned count);
    walk_mode_e        mode;
    int unsigned       push_pct;
    int unsigned       edge_tries;
    int unsigned       edge_limit;
    int unsigned       mix_left;
    action_e           act;
    logic [SidW-1:0]   sid;
    logic [ValueW-1:0] value;
    mode       = MODE_FILL;
    edge_tries = 0;
    edge_limit = $urandom_range(8, 3);
    mix_left   = 0;
    for (int unsigned n = 0; n < count; n++) begin
      push_pct = (mode == MODE_FILL) ? 92 : (mode == MODE_DRAIN) ? 8 : 50;
      act      = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
      sid      = SidW'($urandom_range((1 << SidW) - 1));
      case ($urandom_range(7))
        0:       value = {1'b1, {(ValueW-1){1'b0}}};
        1:       value = {1'b0, {(ValueW-1){1'b1}}};
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      send_item(act, sid, value);
      // Switch mode once the store has sat full or empty for a while, or once the mixed run is used up
      case (mode)
        MODE_FILL: begin
          if (sb.used == Depth) edge_tries++;
          if (edge_tries >= edge_limit) begin
            mode       = MODE_DRAIN;
            edge_tries = 0;
            edge_limit = $urandom_range(8, 3);
          end
        end
        MODE_DRAIN: begin
          if (sb.used == 0) edge_tries++;
          if (edge_tries >= edge_limit) begin
            mode       = MODE_MIX;
            edge_tries = 0;
            edge_limit = $urandom_range(8, 3);
            mix_left   = $urandom_range(120, 40);
          end
        end
        default: begin
          if (mix_left > 0) mix_left--;
          if (mix_left == 0) mode = MODE_FILL;
        end
      endcase
    end
  endtask

  initial begin
    sb              = new();
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    action_i        = ACT_PUSH;
    stack_id_i      = '0;
    push_value_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: value extremes, every stack, underflow on empty stacks
    send_item(ACT_POP,  2'd0, 32'h0000_0000);
    send_item(ACT_PUSH, 2'd0, 32'h7fff_ffff);
    send_item(ACT_PUSH, 2'd0, 32'h8000_0000);
    send_item(ACT_PUSH, 2'd1, 32'h0000_0000);
    send_item(ACT_PUSH, 2'd2, 32'hffff_ffff);
    send_item(ACT_PUSH, 2'd3, 32'haaaa_aaaa);
    send_item(ACT_PUSH, 2'd3, 32'h5555_5555);
    send_item(ACT_POP,  2'd3, 32'hffff_ffff);
    send_item(ACT_POP,  2'd3, 32'h0000_0000);
    send_item(ACT_POP,  2'd3, 32'h0000_0000);
    send_item(ACT_POP,  2'd0, 32'h1234_5678);
    send_item(ACT_PUSH, 2'd1, 32'h0000_0001);
    send_item(ACT_POP,  2'd0, 32'h0000_0000);
    send_item(ACT_POP,  2'd0, 32'h0000_0000);
    send_item(ACT_POP,  2'd1, 32'h0000_0000);
    send_item(ACT_POP,  2'd1, 32'h0000_0000);
    send_item(ACT_POP,  2'd1, 32'h0000_0000);
    send_item(ACT_POP,  2'd2, 32'h0000_0000);
    send_item(ACT_POP,  2'd2, 32'h0000_0000);

    // Random: sender idles lightly, then heavily, then never
    sender_idle_pct = 20;
    run_random(RandomItems / 3);
    sender_idle_pct = 76;
    run_random(RandomItems / 3);
    sender_idle_pct = 0;
    run_random(RandomItems - 2 * (RandomItems / 3));
    start <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (sb.step_results_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kss_pkg.sv
rtl/core/kss_ram.sv
rtl/core/kss_link_store.sv
rtl/core/k_stacks_shared_store.sv
rtl/core/kss_checker.sv
verif/tb_top.sv
